FILE: hw/rtl/ple_pkg.sv
// shared types and constants for the positional list engine
// no dependencies; imported by ple_cell and positional_list_engine
package ple_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SET    = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             set;
        logic [POS_W-1:0] slot;   // 0-based target cell
    } cmd_t;

endpackage

FILE: hw/rtl/positional_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit entries addressed by 1-based
// position, held in a row of DEPTH cells that shift all at once on insert and
// remove. A request is accepted whenever the output register is empty or
// being drained, and its result (status, read value, new length) appears in
// the output register on the next cycle, so a request can be accepted every
// cycle while out_ready drains the output. The cell row updates every entry
// in parallel in the accepting cycle. Rejected requests leave the list
// unchanged. No clearing pass is needed after reset.
// depends on ple_pkg and ple_cell
module positional_list_engine #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ple_pkg::OP_W-1:0]             operation,
    input  logic [ple_pkg::POS_W-1:0]            position,
    input  logic signed [ple_pkg::DATA_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ple_pkg::STATUS_W-1:0]         status,
    output logic signed [ple_pkg::DATA_W-1:0]    read_value,
    output logic [ple_pkg::LEN_W-1:0]            list_length
);
    import ple_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = POS_W + 1;

    logic [CW-1:0]             count_reg, count_next;
    logic                      out_valid_reg;
    status_t                   status_reg, status_next;
    logic signed [DATA_W-1:0]  read_value_reg, read_value_next;
    logic [LEN_W-1:0]          length_reg, length_next;

    logic                      accept;
    logic                      ins_ok, rem_ok, set_ok, get_ok;
    logic [PW-1:0]             pos_ext, cnt_ext;
    logic [CW+LEN_W-1:0]       len_ext;
    logic signed [DATA_W-1:0]  rd_sel;
    cmd_t                      cmd;
    logic signed [DATA_W-1:0]  cell_q [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign pos_ext  = PW'(position);
    assign cnt_ext  = PW'(count_reg);

    // request decode: full / empty checks come before position checks
    always_comb
    begin
        status_next = ST_OK;
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        set_ok = 1'b0;
        get_ok = 1'b0;
        unique case (op_t'(operation))
            OP_INSERT:
            begin
                priority if (cnt_ext >= PW'(DEPTH))
                    status_next = ST_FULL;
                else if (position == '0 || pos_ext > cnt_ext + PW'(1))
                    status_next = ST_BADPOS;
                else
                    ins_ok = 1'b1;
            end
            default:
            begin
                priority if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (position == '0 || pos_ext > cnt_ext)
                    status_next = ST_BADPOS;
                else
                begin
                    rem_ok = (op_t'(operation) == OP_REMOVE);
                    set_ok = (op_t'(operation) == OP_SET);
                    get_ok = (op_t'(operation) == OP_GET);
                end
            end
        endcase
    end

    always_comb
    begin
        cmd.ins  = accept && ins_ok;
        cmd.rem  = accept && rem_ok;
        cmd.set  = accept && set_ok;
        cmd.slot = position - POS_W'(1);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_d, right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end
            ple_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .left_data  (left_d),
                .right_data (right_d),
                .value      (value),
                .data       (cell_q[gi])
            );
        end
    endgenerate

    // and-or select of the addressed cell
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_sel = rd_sel | (cell_q[i] & {DATA_W{POS_W'(i) == cmd.slot}});
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + CW'(1);
        else if (cmd.rem)
            count_next = count_reg - CW'(1);
        len_ext         = (CW+LEN_W)'(count_next);
        length_next     = len_ext[LEN_W-1:0];
        read_value_next = get_ok ? rd_sel : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_ready)
                out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            length_reg     <= length_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign list_length = length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted insert did not grow the list");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status_next != ST_OK |=> count_reg == $past(count_reg))
        else $error("rejected request changed the length");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_FULL |-> count_reg == CW'(DEPTH))
        else $error("full status with room left");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> read_value_reg == '0)
        else $error("read value on a rejected request");

endmodule

FILE: hw/rtl/ple_cell.sv
// one storage cell of the list row: holds a single entry
// depends on ple_pkg for the command struct and widths
module ple_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                               clk,
    input  ple_pkg::cmd_t                      cmd,
    input  logic signed [ple_pkg::DATA_W-1:0]  left_data,
    input  logic signed [ple_pkg::DATA_W-1:0]  right_data,
    input  logic signed [ple_pkg::DATA_W-1:0]  value,
    output logic signed [ple_pkg::DATA_W-1:0]  data
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (cmd.ins && IDX == cmd.slot)
        begin
            data_next = value;
        end
        else if (cmd.ins && IDX > cmd.slot)
        begin
            data_next = left_data;    // shift back by one
        end
        else if (cmd.rem && IDX >= cmd.slot)
        begin
            data_next = right_data;   // close the gap
        end
        else if (cmd.set && IDX == cmd.slot)
        begin
            data_next = value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
